// File: hdl/gtr_pkg.sv
// Shared types, constants and font table for the glyph text rasterizer.
// Used by glyph_text_rasterizer, gtr_edge_unit, gtr_checker and the testbench; depends on nothing.
`default_nettype none
package gtr_pkg;

	localparam int PIXEL_W    = 12;
	localparam int EDGE_W     = 21;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
	localparam int GLYPH_COUNT = 26;
	localparam int GLYPH_ADVANCE = 6;
	localparam int COL_W      = $clog2(GLYPH_COLS);

	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_Z = 8'h5A;

	localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_PIXELS_PER_UNIT = 2'd2;

	localparam logic [1:0] EDGE_LEFT   = 2'd0;
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [1:0] EDGE_TOP    = 2'd2;
	localparam logic [1:0] EDGE_BOTTOM = 2'd3;

	typedef struct packed {
		logic                     valid;
		logic [1:0]               sel;
		logic signed [EDGE_W-1:0] edge2;
		logic [PIXEL_W-1:0]       dim;
	} edge_req_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         sel;
		logic [PIXEL_W-1:0] pixel;
	} edge_rsp_t;

	// top row first, bit 4 of each row is the leftmost cell
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		{5'h0C,5'h12,5'h12,5'h1E,5'h12,5'h12,5'h12},
		{5'h1C,5'h12,5'h12,5'h1C,5'h12,5'h12,5'h1C},
		{5'h1E,5'h12,5'h10,5'h10,5'h10,5'h12,5'h1E},
		{5'h1C,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1C},
		{5'h1E,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1E},
		{5'h1E,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		{5'h1E,5'h12,5'h10,5'h16,5'h12,5'h12,5'h1E},
		{5'h12,5'h12,5'h12,5'h1E,5'h12,5'h12,5'h12},
		{5'h1E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h1E},
		{5'h1E,5'h04,5'h04,5'h04,5'h14,5'h14,5'h1C},
		{5'h12,5'h12,5'h14,5'h18,5'h14,5'h12,5'h12},
		{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1E},
		{5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11},
		{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		{5'h1E,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1E},
		{5'h1C,5'h12,5'h12,5'h1C,5'h10,5'h10,5'h10},
		{5'h1E,5'h12,5'h12,5'h12,5'h12,5'h1E,5'h02},
		{5'h1C,5'h12,5'h12,5'h1C,5'h12,5'h12,5'h12},
		{5'h1E,5'h10,5'h10,5'h0C,5'h02,5'h02,5'h1E},
		{5'h1E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		{5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1E},
		{5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h0C},
		{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0E},
		{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		{5'h1E,5'h02,5'h02,5'h0C,5'h10,5'h10,5'h1E}
	};

	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
		logic [7:0] idx;
		idx = code - LETTER_A;
		if (code >= LETTER_A && code <= LETTER_Z) begin
			return GLYPH_ROM[idx[4:0]];
		end
		return '0;
	endfunction

endpackage
`default_nettype wire

// File: hdl/gtr_edge_unit.sv
// Shared edge unit: scales one doubled world edge by pixels_per_unit, offsets it
// to screen center, truncates and clamps. Three stages. Depends on gtr_pkg.
`default_nettype none
module gtr_edge_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [15:0]       pixels_per_unit,
	input  wire gtr_pkg::edge_req_t req,
	output gtr_pkg::edge_rsp_t     rsp
);
	localparam int PROD_W = gtr_pkg::EDGE_W + 17;
	localparam int SUM_W  = PROD_W + 1;
	localparam int PIX_W  = SUM_W - 17;

	logic                             vld_s1, vld_s2, vld_s3;
	logic [1:0]                       sel_s1, sel_s2, sel_s3;
	logic signed [gtr_pkg::EDGE_W-1:0] edge_s1;
	logic [gtr_pkg::PIXEL_W-1:0]      dim_s1, dim_s2;
	logic signed [PROD_W-1:0]         prod_s2;
	logic [gtr_pkg::PIXEL_W-1:0]      pix_s3;

	logic signed [SUM_W-1:0]          sum;
	logic [PIX_W-1:0]                 whole;
	logic [gtr_pkg::PIXEL_W-1:0]      clamped;

	always_comb begin
		sum = SUM_W'(prod_s2) + $signed({{(SUM_W-gtr_pkg::PIXEL_W-16){1'b0}}, dim_s2, 16'h0000});
		whole = sum[SUM_W-1:17];
		if (sum < 0) begin
			clamped = '0;
		end else if (whole > PIX_W'(dim_s2)) begin
			clamped = dim_s2;
		end else begin
			clamped = whole[gtr_pkg::PIXEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1  <= req.sel;
		edge_s1 <= req.edge2;
		dim_s1  <= req.dim;
		sel_s2  <= sel_s1;
		dim_s2  <= dim_s1;
		prod_s2 <= PROD_W'(edge_s1) * $signed({1'b0, pixels_per_unit});
		sel_s3  <= sel_s2;
		pix_s3  <= clamped;
	end

	assign rsp.valid = vld_s3;
	assign rsp.sel   = sel_s3;
	assign rsp.pixel = pix_s3;

endmodule
`default_nettype wire

// File: hdl/glyph_text_rasterizer.sv
// Bitmap font text rasterizer: one character in, one rectangle per lit glyph cell out.
// Each unlit cell is skipped in the scan state; each lit cell issues its left, right,
// top and bottom edges through the shared three-stage edge unit, waits for them, then
// loads the output beat once free. Input ready only between characters; a code with
// no glyph leaves the block idle. Reset: pen at 0, registers at 1280 x 720 and scale
// 1843, no beat pending. Depends on gtr_pkg and gtr_edge_unit.
`default_nettype none
module glyph_text_rasterizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// letter_code[7:0], start_of_text[8], text_x[24:9], text_y[40:25],
	// cell_size[55:41], ink_color[87:56]
	input  wire logic [87:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// rect_left[11:0], rect_right[23:12], rect_top[35:24], rect_bottom[47:36],
	// rect_color[79:48]
	output logic [79:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int EW = gtr_pkg::EDGE_W;
	localparam int PW = gtr_pkg::PIXEL_W;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_EDGE, ST_WAIT, ST_LOAD} state_t;

	state_t                         state_q;
	logic [PW-1:0]                  width_q, height_q;
	logic [15:0]                    ppu_q;
	logic [15:0]                    pen_q;
	logic [gtr_pkg::GLYPH_BITS-1:0] glyph_q;
	logic [gtr_pkg::COL_W-1:0]      col_q;
	logic signed [EW-1:0]           cx2_q, cy2_q, px2_q;
	logic [14:0]                    cell_q;
	logic [31:0]                    color_q;
	logic [1:0]                     sel_q;
	logic [PW-1:0]                  left_q, right_q, top_q, bottom_q;
	logic                           out_valid_q, out_last_q;
	logic [79:0]                    out_data_q;

	logic [7:0]                     in_code;
	logic                           in_start;
	logic [15:0]                    in_x, in_y;
	logic [14:0]                    in_cell;
	logic [31:0]                    in_color;
	logic [15:0]                    px;
	logic [17:0]                    advance;
	logic [gtr_pkg::GLYPH_BITS-1:0] in_glyph;
	logic signed [EW-1:0]           cell_x, cell2_x;
	logic [gtr_pkg::GLYPH_BITS-1:0] nxt_glyph;
	logic                           out_free;

	gtr_pkg::edge_req_t req;
	gtr_pkg::edge_rsp_t rsp;

	assign in_code  = s_axis_tdata[7:0];
	assign in_start = s_axis_tdata[8];
	assign in_x     = s_axis_tdata[24:9];
	assign in_y     = s_axis_tdata[40:25];
	assign in_cell  = s_axis_tdata[55:41];
	assign in_color = s_axis_tdata[87:56];

	assign px       = in_start ? in_x : pen_q;
	assign advance  = 18'(in_cell) * 18'(gtr_pkg::GLYPH_ADVANCE);
	assign in_glyph = gtr_pkg::glyph_bits(in_code);
	assign cell_x   = $signed({{(EW-15){1'b0}}, cell_q});
	assign cell2_x  = $signed({{(EW-16){1'b0}}, cell_q, 1'b0});
	assign nxt_glyph = {glyph_q[gtr_pkg::GLYPH_BITS-2:0], 1'b0};
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		req.valid = (state_q == ST_EDGE);
		req.sel   = sel_q;
		req.dim   = width_q;
		case (sel_q)
			gtr_pkg::EDGE_LEFT: begin
				req.edge2 = cx2_q - cell_x;
			end
			gtr_pkg::EDGE_RIGHT: begin
				req.edge2 = cx2_q + cell_x;
			end
			gtr_pkg::EDGE_TOP: begin
				req.edge2 = cy2_q - cell_x;
				req.dim   = height_q;
			end
			default: begin
				req.edge2 = cy2_q + cell_x;
				req.dim   = height_q;
			end
		endcase
	end

	gtr_edge_unit u_edge (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixels_per_unit (ppu_q),
		.req             (req),
		.rsp             (rsp)
	);

	always_ff @(posedge clk) begin
		if (rsp.valid) begin
			case (rsp.sel)
				gtr_pkg::EDGE_LEFT:  left_q   <= rsp.pixel;
				gtr_pkg::EDGE_RIGHT: right_q  <= rsp.pixel;
				gtr_pkg::EDGE_TOP:   top_q    <= rsp.pixel;
				default:             bottom_q <= rsp.pixel;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= 12'd1280;
			height_q    <= 12'd720;
			ppu_q       <= 16'd1843;
			pen_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
			glyph_q     <= '0;
			col_q       <= '0;
			sel_q       <= gtr_pkg::EDGE_LEFT;
			cx2_q       <= '0;
			cy2_q       <= '0;
			px2_q       <= '0;
			cell_q      <= '0;
			color_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					gtr_pkg::CFG_SCREEN_WIDTH:    width_q  <= cfg_data[PW-1:0];
					gtr_pkg::CFG_SCREEN_HEIGHT:   height_q <= cfg_data[PW-1:0];
					gtr_pkg::CFG_PIXELS_PER_UNIT: ppu_q    <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && m_axis_tready && state_q != ST_LOAD) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						pen_q   <= px + advance[15:0];
						px2_q   <= $signed({{(EW-17){px[15]}}, px, 1'b0});
						cx2_q   <= $signed({{(EW-17){px[15]}}, px, 1'b0});
						cy2_q   <= $signed({{(EW-17){in_y[15]}}, in_y, 1'b0});
						cell_q  <= in_cell;
						color_q <= in_color;
						glyph_q <= in_glyph;
						col_q   <= '0;
						if (in_glyph != '0) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (glyph_q[gtr_pkg::GLYPH_BITS-1]) begin
						sel_q   <= gtr_pkg::EDGE_LEFT;
						state_q <= ST_EDGE;
					end else begin
						glyph_q <= nxt_glyph;
						if (col_q == gtr_pkg::COL_W'(gtr_pkg::GLYPH_COLS - 1)) begin
							col_q <= '0;
							cx2_q <= px2_q;
							cy2_q <= cy2_q - cell2_x;
						end else begin
							col_q <= col_q + 1'b1;
							cx2_q <= cx2_q + cell2_x;
						end
						state_q <= (nxt_glyph == '0) ? ST_IDLE : ST_SCAN;
					end
				end
				ST_EDGE: begin
					sel_q <= sel_q + 1'b1;
					if (sel_q == gtr_pkg::EDGE_BOTTOM) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rsp.valid && rsp.sel == gtr_pkg::EDGE_BOTTOM) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= (nxt_glyph == '0);
						out_data_q  <= {color_q, bottom_q, top_q, right_q, left_q};
						glyph_q     <= nxt_glyph;
						if (col_q == gtr_pkg::COL_W'(gtr_pkg::GLYPH_COLS - 1)) begin
							col_q <= '0;
							cx2_q <= px2_q;
							cy2_q <= cy2_q - cell2_x;
						end else begin
							col_q <= col_q + 1'b1;
							cx2_q <= cx2_q + cell2_x;
						end
						state_q <= (nxt_glyph == '0) ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/gtr_checker.sv
// Port-level checks for glyph_text_rasterizer, attached by bind.
// Depends on the top level's ports and gtr_pkg.
`default_nettype none
module gtr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [87:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	logic lit_code;
	assign lit_code = (s_axis_tdata[7:0] >= gtr_pkg::LETTER_A) &&
		(s_axis_tdata[7:0] <= gtr_pkg::LETTER_Z);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	a_busy_after_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && lit_code |=> !s_axis_tready)
		else $error("ready stayed high after a drawable character");

	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("idle with a non-final rectangle pending");

	a_no_invalid_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !lit_code |=> s_axis_tready)
		else $error("busy after a character with no glyph");

endmodule

bind glyph_text_rasterizer gtr_checker u_gtr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_text_rasterizer: directed and random text on the
// slave stream, with a predictor for every rectangle. Depends on gtr_pkg and the RTL.
module testbench;

	localparam int         HALF_PERIOD    = 5;
	localparam int         DRAIN_CYCLES   = 320;
	localparam int         HOLD_CYCLES    = 600;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         IDLE_PCT       = 20;
	localparam logic [1:0] CFG_UNUSED     = 2'd3;

	typedef struct packed {
		logic [31:0]        ink;
		logic [14:0]        cell_sz;
		logic signed [15:0] text_y;
		logic signed [15:0] text_x;
		logic               start;
		logic [7:0]         code;
	} letter_t;

	typedef struct packed {
		logic        last;
		logic [31:0] color;
		logic [11:0] bottom;
		logic [11:0] top;
		logic [11:0] right;
		logic [11:0] left;
	} rect_t;

	// top row first, bit 4 is the leftmost cell
	localparam logic [4:0] FONT [26][7] = '{
		'{5'h0C,5'h12,5'h12,5'h1E,5'h12,5'h12,5'h12},
		'{5'h1C,5'h12,5'h12,5'h1C,5'h12,5'h12,5'h1C},
		'{5'h1E,5'h12,5'h10,5'h10,5'h10,5'h12,5'h1E},
		'{5'h1C,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1C},
		'{5'h1E,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1E},
		'{5'h1E,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		'{5'h1E,5'h12,5'h10,5'h16,5'h12,5'h12,5'h1E},
		'{5'h12,5'h12,5'h12,5'h1E,5'h12,5'h12,5'h12},
		'{5'h1E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h1E},
		'{5'h1E,5'h04,5'h04,5'h04,5'h14,5'h14,5'h1C},
		'{5'h12,5'h12,5'h14,5'h18,5'h14,5'h12,5'h12},
		'{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1E},
		'{5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11},
		'{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		'{5'h1E,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1E},
		'{5'h1C,5'h12,5'h12,5'h1C,5'h10,5'h10,5'h10},
		'{5'h1E,5'h12,5'h12,5'h12,5'h12,5'h1E,5'h02},
		'{5'h1C,5'h12,5'h12,5'h1C,5'h12,5'h12,5'h12},
		'{5'h1E,5'h10,5'h10,5'h0C,5'h02,5'h02,5'h1E},
		'{5'h1E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		'{5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1E},
		'{5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h0C},
		'{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0E},
		'{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		'{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		'{5'h1E,5'h02,5'h02,5'h0C,5'h10,5'h10,5'h1E}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// letter_code[7:0], start_of_text[8], text_x[24:9], text_y[40:25],
	// cell_size[55:41], ink_color[87:56]
	logic [87:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// rect_left[11:0], rect_right[23:12], rect_top[35:24], rect_bottom[47:36],
	// rect_color[79:48]
	logic [79:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	glyph_text_rasterizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// predictor state
	logic [11:0]        scr_w = 12'd1280;
	logic [11:0]        scr_h = 12'd720;
	logic [15:0]        scale_q8 = 16'd1843;
	logic signed [15:0] pen_q8 = '0;

	rect_t rect_q[$];
	rect_t got_rect;
	rect_t want_rect;

	logic tx_idle_on = 1'b1;
	logic rx_idle_on = 1'b1;
	logic rx_hold = 1'b0;

	int errors = 0;
	int letters_sent = 0;
	int blank_letters = 0;
	int rects_seen = 0;
	int reg_writes = 0;
	int stall_count = 0;

	function automatic logic [11:0] edge_pixel(longint edge2, logic [11:0] dim);
		longint acc;
		longint pix;
		acc = edge2 * longint'(scale_q8) + longint'(dim) * 65536;
		if (acc < 0) begin
			return '0;
		end
		pix = acc >>> 17;
		if (pix > longint'(dim)) begin
			pix = longint'(dim);
		end
		return pix[11:0];
	endfunction

	function automatic void predict_rects(letter_t it);
		longint px;
		longint cell_len;
		longint cx2;
		longint cy2;
		int     g;
		rect_t  rc;
		rect_t  cells[$];
		cell_len = longint'(it.cell_sz);
		if (it.start) begin
			pen_q8 = it.text_x;
		end
		px = longint'($signed(pen_q8));
		if (it.code >= gtr_pkg::LETTER_A && it.code <= gtr_pkg::LETTER_Z) begin
			g = int'(it.code - gtr_pkg::LETTER_A);
			for (int r = 0; r < gtr_pkg::GLYPH_ROWS; r++) begin
				cy2 = 2 * (longint'($signed(it.text_y)) - longint'(r) * cell_len);
				for (int c = 0; c < 5; c++) begin
					if (FONT[g][r][4 - c]) begin
						cx2 = 2 * (px + longint'(c) * cell_len);
						rc.left = edge_pixel(cx2 - cell_len, scr_w);
						rc.right = edge_pixel(cx2 + cell_len, scr_w);
						rc.top = edge_pixel(cy2 - cell_len, scr_h);
						rc.bottom = edge_pixel(cy2 + cell_len, scr_h);
						rc.color = it.ink;
						rc.last = 1'b0;
						cells.push_back(rc);
					end
				end
			end
		end else begin
			blank_letters++;
		end
		if (cells.size() > 0) begin
			cells[cells.size() - 1].last = 1'b1;
		end
		foreach (cells[i]) begin
			rect_q.push_back(cells[i]);
		end
		pen_q8 = pen_q8 + 16'(gtr_pkg::GLYPH_ADVANCE * int'(it.cell_sz));
	endfunction

	task automatic send_letter(letter_t it);
		predict_rects(it);
		letters_sent++;
		if (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic hold_input();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		hold_input();
		while (rect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			gtr_pkg::CFG_SCREEN_WIDTH:    scr_w = value[11:0];
			gtr_pkg::CFG_SCREEN_HEIGHT:   scr_h = value[11:0];
			gtr_pkg::CFG_PIXELS_PER_UNIT: scale_q8 = value;
			default: ;
		endcase
	endtask

	task automatic set_screen(logic [15:0] w, logic [15:0] h, logic [15:0] ppu);
		wait_drained();
		write_reg(gtr_pkg::CFG_SCREEN_WIDTH, w);
		write_reg(gtr_pkg::CFG_SCREEN_HEIGHT, h);
		write_reg(gtr_pkg::CFG_PIXELS_PER_UNIT, ppu);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coord();
		if ($urandom_range(0, 3) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(0, 10240)) - 16'd5120;
	endfunction

	function automatic logic [14:0] pick_cell();
		case ($urandom_range(0, 9))
			0: return 15'($urandom);
			1: return 15'($urandom_range(0, 8));
			default: return 15'($urandom_range(64, 768));
		endcase
	endfunction

	function automatic letter_t noise_letter();
		letter_t it;
		it.code = 8'($urandom);
		it.start = 1'($urandom);
		it.text_x = 16'($urandom);
		it.text_y = 16'($urandom);
		it.cell_sz = 15'($urandom);
		it.ink = $urandom;
		return it;
	endfunction

	// one word on a baseline, with a share of stray beats mixed in
	task automatic send_string(int n, int noise_pct);
		letter_t it;
		it.text_x = pick_coord();
		it.text_y = pick_coord();
		it.cell_sz = pick_cell();
		it.ink = $urandom;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_letter(noise_letter());
			end else begin
				it.start = (k == 0);
				it.code = gtr_pkg::LETTER_A + 8'($urandom_range(0, 25));
				send_letter(it);
			end
		end
	endtask

	task automatic test_directed_letters();
		letter_t    it;
		logic [7:0] odd_codes [6];
		odd_codes = '{8'h40, 8'h5B, 8'h00, 8'hFF, 8'h61, 8'h20};
		it = '{ink: 32'h0, cell_sz: 15'd256, text_y: 16'sd0, text_x: 16'sd0,
			start: 1'b1, code: gtr_pkg::LETTER_A};
		send_letter(it);
		it.start = 1'b0;
		it.ink = 32'hFFFF_FFFF;
		it.code = gtr_pkg::LETTER_Z;
		send_letter(it);
		it.code = "M";
		send_letter(it);
		it.code = "W";
		send_letter(it);
		foreach (odd_codes[i]) begin
			it.code = odd_codes[i];
			send_letter(it);
		end
		it.code = "Q";
		send_letter(it);
		it = '{ink: 32'hA5A5_5A5A, cell_sz: 15'h7FFF, text_y: 16'sh7FFF, text_x: 16'sh7FFF,
			start: 1'b1, code: "H"};
		send_letter(it);
		it = '{ink: 32'h5A5A_A5A5, cell_sz: 15'h0, text_y: -16'sh8000, text_x: -16'sh8000,
			start: 1'b1, code: "W"};
		send_letter(it);
		it.start = 1'b0;
		it.code = "X";
		send_letter(it);
		// pen wraps past the positive limit
		it = '{ink: 32'h00FF_00FF, cell_sz: 15'd1024, text_y: 16'sd512, text_x: 16'sh7000,
			start: 1'b1, code: "E"};
		send_letter(it);
		it.start = 1'b0;
		repeat (3) send_letter(it);
		it.code = "S";
		it.text_y = -16'sd20000;
		send_letter(it);
		it.code = "J";
		it.text_y = 16'sd20000;
		send_letter(it);
	endtask

	task automatic test_register_extremes();
		set_screen(16'd4095, 16'd4095, 16'hFFFF);
		repeat (2) send_string(8, 10);
		set_screen(16'd1, 16'd1, 16'd1);
		send_string(8, 10);
		set_screen(16'd0, 16'd0, 16'd0);
		send_string(8, 10);
		set_screen(16'hF320, 16'hA1E0, 16'd256);
		send_string(8, 10);
		wait_drained();
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_string(8, 10);
		set_screen(16'd1280, 16'd720, 16'd1843);
		send_string(8, 10);
	endtask

	task automatic test_random_text();
		for (int ph = 0; ph < 4; ph++) begin
			if (ph[0]) begin
				set_screen(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
					16'($urandom));
			end else begin
				set_screen(16'($urandom_range(160, 1920)), 16'($urandom_range(120, 1080)),
					16'($urandom_range(256, 4096)));
			end
			while (letters_sent < 112 + 55 * (ph + 1)) begin
				send_string($urandom_range(1, 12), 15);
			end
		end
	endtask

	task automatic test_back_to_back();
		wait_drained();
		tx_idle_on <= 1'b0;
		rx_idle_on <= 1'b0;
		repeat (6) send_string(10, 5);
		hold_input();
		tx_idle_on <= 1'b1;
		rx_idle_on <= 1'b1;
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (4) send_string(10, 5);
	endtask

	task automatic test_input_pause();
		repeat (2) send_string(10, 10);
		hold_input();
		while (rect_q.size() != 0) @(posedge clk);
		repeat (2) send_string(10, 10);
	endtask

	// receiver: check each result beat, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_rect = {m_axis_tlast, m_axis_tdata};
			rects_seen++;
			if (rect_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Mismatch: unexpected rectangle l=%0d r=%0d t=%0d b=%0d c=%h last=%0b",
						got_rect.left, got_rect.right, got_rect.top, got_rect.bottom,
						got_rect.color, got_rect.last);
				end
			end else begin
				want_rect = rect_q.pop_front();
				if (got_rect != want_rect) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch: expected l=%0d r=%0d t=%0d b=%0d c=%h last=%0b",
							want_rect.left, want_rect.right, want_rect.top, want_rect.bottom,
							want_rect.color, want_rect.last);
						$display("          actual   l=%0d r=%0d t=%0d b=%0d c=%h last=%0b",
							got_rect.left, got_rect.right, got_rect.top, got_rect.bottom,
							got_rect.color, got_rect.last);
					end
				end
			end
		end
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (rx_idle_on) begin
			m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog: count cycles with no beat on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			stall_count <= 0;
		end else if (stall_count >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat for %0d cycles, %0d rectangles pending",
				stall_count, rect_q.size());
			$display("FAIL glyph_text_rasterizer");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_letters();
		test_register_extremes();
		test_random_text();
		test_back_to_back();
		test_output_backpressure();
		test_input_pause();
		hold_input();
		while (rect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += rect_q.size();
		$display("Sent %0d characters (%0d without a glyph) over %0d register writes,",
			letters_sent, blank_letters, reg_writes);
		$display("checked %0d rectangles, %0d mismatches.", rects_seen, errors);
		if (errors == 0) begin
			$display("PASS glyph_text_rasterizer");
		end else begin
			$display("FAIL glyph_text_rasterizer");
		end
		$finish;
	end

endmodule
